@@ design/sbdt_pkg.sv @@
// Shared types and constants for the slot-budget device table.
package sbdt_pkg;

    // Field widths fixed by the interface.
    localparam int FUNC_W  = 2;
    localparam int MAC_W   = 48;
    localparam int MODE_W  = 8;
    localparam int INDEX_W = 6;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 7;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd2;

    // Slot costs of an entry by mode.
    localparam logic [1:0] COST_WIDE   = 2'd2;
    localparam logic [1:0] COST_NARROW = 2'd1;

    // One stored table entry.
    typedef struct packed {
        logic [MAC_W-1:0]  addr;
        logic [MODE_W-1:0] mode;
        logic              seen;
        logic [TIME_W-1:0] last_seen;
    } sbdt_entry_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK_RD,
        S_LOOK_CMP,
        S_ADD,
        S_RM_RD,
        S_RM_MODE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_RM_CLEAR,
        S_DONE
    } sbdt_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd_cur;
        logic rd_next;
        logic set_hit;
        logic wr_refresh;
        logic wr_append;
        logic cap_freed;
        logic wr_shift;
        logic ptr_inc;
        logic wr_clear;
    } sbdt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [FUNC_W-1:0] req_func;
        logic [FUNC_W-1:0] func;
        logic              ptr_lt_used;
        logic              next_lt_used;
        logic              match;
        logic              can_add;
    } sbdt_status_t;

endpackage

@@ design/sbdt_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module sbdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/sbdt_ctrl.sv @@
// Controller state machine sequencing lookup, append, refresh and removal.
module sbdt_ctrl import sbdt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  sbdt_status_t status,
    output sbdt_cmd_t    cmd,
    output logic         busy,
    output logic         done
);

    sbdt_state_t state_reg;
    sbdt_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic; an idle start dispatches on the operation being offered.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (status.req_func == FUNC_ADD || status.req_func == FUNC_FIND)
                    begin
                        state_next = S_LOOK_RD;
                    end
                    else if (status.req_func == FUNC_REMOVE)
                    begin
                        state_next = S_RM_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_LOOK_RD:
            begin
                if (status.ptr_lt_used)
                begin
                    state_next = S_LOOK_CMP;
                end
                else if (status.func == FUNC_ADD)
                begin
                    state_next = S_ADD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_LOOK_CMP:
            begin
                state_next = status.match ? S_DONE : S_LOOK_RD;
            end
            S_ADD:
            begin
                state_next = S_DONE;
            end
            S_RM_RD:
            begin
                state_next = status.ptr_lt_used ? S_RM_MODE : S_DONE;
            end
            S_RM_MODE:
            begin
                state_next = S_SHIFT_RD;
            end
            S_SHIFT_RD:
            begin
                state_next = status.next_lt_used ? S_SHIFT_WR : S_RM_CLEAR;
            end
            S_SHIFT_WR:
            begin
                state_next = S_SHIFT_RD;
            end
            S_RM_CLEAR:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output logic: datapath commands and handshake flags.
    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != S_IDLE);
        done = (state_reg == S_DONE);
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
            end
            S_LOOK_RD:
            begin
                cmd.rd_cur = status.ptr_lt_used;
            end
            S_LOOK_CMP:
            begin
                cmd.set_hit    = status.match;
                cmd.wr_refresh = status.match && (status.func == FUNC_ADD);
                cmd.ptr_inc    = !status.match;
            end
            S_ADD:
            begin
                cmd.wr_append = status.can_add;
            end
            S_RM_RD:
            begin
                cmd.rd_cur = status.ptr_lt_used;
            end
            S_RM_MODE:
            begin
                cmd.cap_freed = 1'b1;
            end
            S_SHIFT_RD:
            begin
                cmd.rd_next = status.next_lt_used;
            end
            S_SHIFT_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.ptr_inc  = 1'b1;
            end
            S_RM_CLEAR:
            begin
                cmd.wr_clear = 1'b1;
            end
            S_DONE:
            begin
                cmd = '0;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ design/sbdt_datapath.sv @@
// Datapath: operand registers, counters, scan pointer and the entry memory.
module sbdt_datapath import sbdt_pkg::*;
#(
    parameter int SLOT_BUDGET = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [FUNC_W-1:0]  func,
    input  logic [MAC_W-1:0]   mac,
    input  logic [MODE_W-1:0]  pedal_mode,
    input  logic [INDEX_W-1:0] entry_index,
    input  logic [TIME_W-1:0]  now_ms,
    input  sbdt_cmd_t          cmd,
    output sbdt_status_t       status,
    output logic               ok,
    output logic               found,
    output logic [INDEX_W-1:0] found_index,
    output logic [COUNT_W-1:0] available_slots,
    output logic [COUNT_W-1:0] entry_count
);

    localparam int AW = (SLOT_BUDGET > 1) ? $clog2(SLOT_BUDGET) : 1;
    localparam logic [COUNT_W-1:0] BUDGET = COUNT_W'(SLOT_BUDGET);

    // Operand registers, captured when an operation starts.
    logic [FUNC_W-1:0]  func_reg;
    logic [MAC_W-1:0]   mac_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [TIME_W-1:0]  now_reg;

    // Table occupancy and working registers.
    logic [COUNT_W-1:0] used_entries_reg;
    logic [COUNT_W-1:0] used_slots_reg;
    logic [COUNT_W-1:0] ptr_reg;
    logic [1:0]         freed_reg;
    logic               ok_reg;
    logic               hit_reg;
    logic [INDEX_W-1:0] pos_reg;

    logic [COUNT_W-1:0] ptr_plus1;
    logic [1:0]         need;
    logic [COUNT_W-1:0] slots_after_add;

    sbdt_entry_t        rd_entry;
    sbdt_entry_t        wr_entry;
    logic               wr_en;
    logic               rd_en;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;

    assign ptr_plus1       = ptr_reg + COUNT_W'(1);
    assign need            = (mode_reg == '0) ? COST_WIDE : COST_NARROW;
    assign slots_after_add = used_slots_reg + COUNT_W'(need);

    // Status towards the controller; req_func is the operation on offer.
    always_comb
    begin
        status.req_func     = func;
        status.func         = func_reg;
        status.ptr_lt_used  = (ptr_reg < used_entries_reg);
        status.next_lt_used = (ptr_plus1 < used_entries_reg);
        status.match        = (rd_entry.addr == mac_reg);
        status.can_add      = (slots_after_add <= BUDGET) && (used_entries_reg < BUDGET);
    end

    // Operand capture; the pointer starts at the removal index or at zero.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            mac_reg  <= mac;
            mode_reg <= pedal_mode;
            now_reg  <= now_ms;
        end
    end

    // Scan pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.load)
        begin
            ptr_reg <= (func == FUNC_REMOVE) ? COUNT_W'(entry_index) : '0;
        end
        else if (cmd.ptr_inc)
        begin
            ptr_reg <= ptr_plus1;
        end
    end

    // Result flags and position of the matching entry.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ok_reg  <= 1'b0;
            hit_reg <= 1'b0;
            pos_reg <= '0;
        end
        else if (cmd.set_hit)
        begin
            ok_reg  <= 1'b1;
            hit_reg <= 1'b1;
            pos_reg <= ptr_reg[INDEX_W-1:0];
        end
        else if (cmd.wr_append || cmd.wr_clear)
        begin
            ok_reg <= 1'b1;
        end
    end

    // Slot cost of the entry being removed.
    always_ff @(posedge clk)
    begin
        if (cmd.cap_freed)
        begin
            freed_reg <= (rd_entry.mode == '0) ? COST_WIDE : COST_NARROW;
        end
    end

    // Entry and slot counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_entries_reg <= '0;
            used_slots_reg   <= '0;
        end
        else if (cmd.wr_append)
        begin
            used_entries_reg <= used_entries_reg + COUNT_W'(1);
            used_slots_reg   <= slots_after_add;
        end
        else if (cmd.wr_clear)
        begin
            used_entries_reg <= used_entries_reg - COUNT_W'(1);
            used_slots_reg   <= (used_slots_reg >= COUNT_W'(freed_reg))
                                ? used_slots_reg - COUNT_W'(freed_reg) : '0;
        end
    end

    // Memory write port selection.
    always_comb
    begin
        wr_en    = cmd.wr_refresh || cmd.wr_append || cmd.wr_shift || cmd.wr_clear;
        wr_addr  = ptr_reg[AW-1:0];
        wr_entry = '0;
        priority if (cmd.wr_refresh)
        begin
            wr_entry.addr      = mac_reg;
            wr_entry.mode      = rd_entry.mode;
            wr_entry.seen      = 1'b1;
            wr_entry.last_seen = now_reg;
        end
        else if (cmd.wr_append)
        begin
            wr_addr            = used_entries_reg[AW-1:0];
            wr_entry.addr      = mac_reg;
            wr_entry.mode      = mode_reg;
            wr_entry.seen      = 1'b1;
            wr_entry.last_seen = now_reg;
        end
        else if (cmd.wr_shift)
        begin
            wr_entry = rd_entry;
        end
        else
        begin
            wr_entry = '0;
        end
    end

    // Memory read port: current entry or the one after it.
    assign rd_en   = cmd.rd_cur || cmd.rd_next;
    assign rd_addr = cmd.rd_next ? ptr_plus1[AW-1:0] : ptr_reg[AW-1:0];

    sbdt_ram #(
        .WIDTH ($bits(sbdt_entry_t)),
        .DEPTH (SLOT_BUDGET)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    // Result fields.
    assign ok              = ok_reg;
    assign found           = hit_reg;
    assign found_index     = pos_reg;
    assign available_slots = BUDGET - used_slots_reg;
    assign entry_count     = used_entries_reg;

endmodule

@@ design/slot_budget_device_table_core.sv @@
// Top level of the slot-budget peer device table.
//
//  Channel   Handshake                Beat contents
//  -------   ---------                -------------
//  command   start while busy is low  func, mac, pedal_mode, entry_index, now_ms
//  result    done, one cycle          ok, found, found_index, available_slots,
//                                     entry_count
//
// Each command takes its own run of cycles through the controller; a new one is
// accepted only while busy is low. Find and add scan the N valid entries through
// the memory's single read port, a read state and a compare state per entry, up
// to a hit. A removal shifts each later entry down through a read and a write
// state; a refused removal ends after its first state and the unused selector
// goes straight to the result beat. busy falls the cycle after the beat.
// The result beat appears on done for one cycle and cannot be held off.
// An asynchronous low rst_n empties the table; no clearing pass is needed.
module slot_budget_device_table_core import sbdt_pkg::*;
#(
    parameter int SLOT_BUDGET = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [FUNC_W-1:0]  func,
    input  logic [MAC_W-1:0]   mac,
    input  logic [MODE_W-1:0]  pedal_mode,
    input  logic [INDEX_W-1:0] entry_index,
    input  logic [TIME_W-1:0]  now_ms,
    output logic               done,
    output logic               ok,
    output logic               found,
    output logic [INDEX_W-1:0] found_index,
    output logic [COUNT_W-1:0] available_slots,
    output logic [COUNT_W-1:0] entry_count
);

    sbdt_cmd_t    cmd;
    sbdt_status_t status;

    // Controller.
    sbdt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Datapath and entry memory.
    sbdt_datapath #(
        .SLOT_BUDGET (SLOT_BUDGET)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .func            (func),
        .mac             (mac),
        .pedal_mode      (pedal_mode),
        .entry_index     (entry_index),
        .now_ms          (now_ms),
        .cmd             (cmd),
        .status          (status),
        .ok              (ok),
        .found           (found),
        .found_index     (found_index),
        .available_slots (available_slots),
        .entry_count     (entry_count)
    );

`ifndef SYNTHESIS
    // An accepted command makes the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but block not busy");

    // A result beat is only given while an operation is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result beat outside an operation");

    // A result beat is never repeated back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat repeated");

    // Occupancy never exceeds the budget.
    assert property (@(posedge clk) disable iff (!rst_n)
        (entry_count <= COUNT_W'(SLOT_BUDGET)) && (available_slots <= COUNT_W'(SLOT_BUDGET)))
        else $error("table occupancy beyond slot budget");
`endif

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the slot-budget peer device table core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sbdt_pkg::*;

    localparam int TABLE_DEPTH  = 4;
    localparam int RANDOM_ITEMS = 1530;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 30;
    localparam int QUIET_FROM   = 600;
    localparam int QUIET_TO     = 900;

    // The fourth selector value has no operation behind it.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam logic [MAC_W-1:0]  MAC_ONES  = '1;
    localparam logic [MAC_W-1:0]  MAC_ZERO  = '0;
    localparam logic [TIME_W-1:0] TIME_ONES = '1;

    // One command beat as offered to the block.
    typedef struct {
        logic [FUNC_W-1:0]  func;
        logic [MAC_W-1:0]   mac;
        logic [MODE_W-1:0]  mode;
        logic [INDEX_W-1:0] index;
        logic [TIME_W-1:0]  now;
        bit                 drain;
    } table_cmd_t;

    // One result beat as the table should report it.
    typedef struct {
        logic               ok;
        logic               found;
        logic [INDEX_W-1:0] found_index;
        logic [COUNT_W-1:0] avail;
        logic [COUNT_W-1:0] count;
    } table_outcome_t;

    logic               clk;
    logic               rst_n       = 1'b0;
    logic               start       = 1'b0;
    logic [FUNC_W-1:0]  func        = '0;
    logic [MAC_W-1:0]   mac         = '0;
    logic [MODE_W-1:0]  pedal_mode  = '0;
    logic [INDEX_W-1:0] entry_index = '0;
    logic [TIME_W-1:0]  now_ms      = '0;
    logic               busy;
    logic               done;
    logic               ok;
    logic               found;
    logic [INDEX_W-1:0] found_index;
    logic [COUNT_W-1:0] available_slots;
    logic [COUNT_W-1:0] entry_count;

    table_cmd_t     cmd_backlog[$];
    table_outcome_t table_outcomes[$];

    // Shadow copy of the table contents and its occupancy.
    sbdt_entry_t peer_table[TABLE_DEPTH];
    int          peer_count;
    int          slots_used;

    bit took_beat = 1'b0;
    int mismatch_count = 0;
    int stall_cycles = 0;
    int sent_count = 0;
    int op_tally[4] = '{0, 0, 0, 0};
    int ok_tally = 0;

    slot_budget_device_table_core #(
        .SLOT_BUDGET(TABLE_DEPTH)
    ) uut (.*);

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Applies one command to the shadow table and returns the result it should give.
    function automatic table_outcome_t apply_table_op(table_cmd_t c);
        table_outcome_t r;
        bit             hit;
        int             pos;
        int             cost;
        int             idx;
        r = '{default: '0};
        hit = 1'b0;
        pos = 0;
        idx = int'(c.index);
        // Only live entries take part in the match; the lowest index wins.
        for (int i = 0; i < peer_count; i++)
        begin
            if (!hit && peer_table[i].addr == c.mac)
            begin
                hit = 1'b1;
                pos = i;
            end
        end
        case (c.func)
            FUNC_ADD:
            begin
                if (hit)
                begin
                    peer_table[pos].last_seen = c.now;
                    peer_table[pos].seen = 1'b1;
                    r.ok = 1'b1;
                    r.found = 1'b1;
                    r.found_index = INDEX_W'(pos);
                end
                else
                begin
                    cost = (c.mode == 0) ? int'(COST_WIDE) : int'(COST_NARROW);
                    if (slots_used + cost <= TABLE_DEPTH && peer_count < TABLE_DEPTH)
                    begin
                        peer_table[peer_count] = '{c.mac, c.mode, 1'b1, c.now};
                        peer_count++;
                        slots_used += cost;
                        r.ok = 1'b1;
                    end
                end
            end
            FUNC_REMOVE:
            begin
                if (idx < peer_count)
                begin
                    cost = (peer_table[idx].mode == 0) ? int'(COST_WIDE) : int'(COST_NARROW);
                    for (int i = idx; i + 1 < peer_count; i++)
                        peer_table[i] = peer_table[i + 1];
                    peer_count--;
                    slots_used = (slots_used >= cost) ? slots_used - cost : 0;
                    peer_table[peer_count] = '0;
                    r.ok = 1'b1;
                end
            end
            FUNC_FIND:
            begin
                if (hit)
                begin
                    r.ok = 1'b1;
                    r.found = 1'b1;
                    r.found_index = INDEX_W'(pos);
                end
            end
            default:
            begin
            end
        endcase
        r.avail = COUNT_W'(TABLE_DEPTH - slots_used);
        r.count = COUNT_W'(peer_count);
        return r;
    endfunction

    function automatic table_cmd_t make_cmd(logic [FUNC_W-1:0] f, logic [MAC_W-1:0] m,
                                            logic [MODE_W-1:0] md, logic [INDEX_W-1:0] ix,
                                            logic [TIME_W-1:0] t, bit drain);
        table_cmd_t c;
        c = '{f, m, md, ix, t, drain};
        return c;
    endfunction

    function automatic logic [MAC_W-1:0] random_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[MAC_W-1:0];
    endfunction

    // Directed opening: empty table, budget exhaustion, refresh, shifts and refusals.
    task automatic load_directed();
        logic [MAC_W-1:0] peer_a;
        logic [MAC_W-1:0] peer_b;
        logic [MAC_W-1:0] peer_c;
        logic [MAC_W-1:0] peer_d;
        peer_a = 48'hA5A5_0000_1234;
        peer_b = 48'h5A5A_FFFF_EDCB;
        peer_c = 48'h0123_4567_89AB;
        peer_d = 48'hFEDC_BA98_7654;
        cmd_backlog.push_back(make_cmd(FUNC_FIND, MAC_ZERO, 8'd0, 6'd0, '0, 1'b0));
        cmd_backlog.push_back(make_cmd(FUNC_REMOVE, MAC_ZERO, 8'd0, 6'd0, '0, 1'b0));
        cmd_backlog.push_back(make_cmd(FUNC_UNUSED, MAC_ONES, 8'hFF, 6'd63, TIME_ONES, 1'b0));
        cmd_backlog.push_back(make_cmd(FUNC_ADD, MAC_ONES, 8'd0, 6'd0, TIME_ONES, 1'b0));
        cmd_backlog.push_back(make_cmd(FUNC_ADD, MAC_ZERO, 8'hFF, 6'd0, '0, 1'b0));
        cmd_backlog.push_back(make_cmd(FUNC_ADD, MAC_ZERO, 8'd0, 6'd0, 32'h1234, 1'b0));
        cmd_backlog.push_back(make_cmd(FUNC_ADD, peer_a, 8'd1, 6'd0, 32'h10, 1'b0));
        cmd_backlog.push_back(make_cmd(FUNC_ADD, peer_b, 8'd0, 6'd0, 32'h20, 1'b0));
        cmd_backlog.push_back(make_cmd(FUNC_ADD, peer_b, 8'd1, 6'd0, 32'h30, 1'b0));
        cmd_backlog.push_back(make_cmd(FUNC_FIND, MAC_ONES, 8'd0, 6'd0, '0, 1'b0));
        cmd_backlog.push_back(make_cmd(FUNC_FIND, peer_a, 8'd0, 6'd0, '0, 1'b0));
        cmd_backlog.push_back(make_cmd(FUNC_REMOVE, MAC_ZERO, 8'd0, 6'd63, '0, 1'b0));
        cmd_backlog.push_back(make_cmd(FUNC_REMOVE, MAC_ZERO, 8'd0, 6'd3, '0, 1'b0));
        cmd_backlog.push_back(make_cmd(FUNC_REMOVE, MAC_ZERO, 8'd0, 6'd0, '0, 1'b1));
        cmd_backlog.push_back(make_cmd(FUNC_FIND, peer_a, 8'd0, 6'd0, '0, 1'b0));
        cmd_backlog.push_back(make_cmd(FUNC_ADD, peer_c, 8'd1, 6'd0, 32'h40, 1'b0));
        cmd_backlog.push_back(make_cmd(FUNC_ADD, peer_d, 8'h80, 6'd0, 32'h50, 1'b0));
        cmd_backlog.push_back(make_cmd(FUNC_ADD, peer_b, 8'd1, 6'd0, 32'h60, 1'b0));
        cmd_backlog.push_back(make_cmd(FUNC_REMOVE, MAC_ZERO, 8'd0, 6'd3, '0, 1'b0));
        cmd_backlog.push_back(make_cmd(FUNC_FIND, peer_d, 8'd0, 6'd0, '0, 1'b0));
        cmd_backlog.push_back(make_cmd(FUNC_REMOVE, MAC_ZERO, 8'd0, 6'd1, '0, 1'b0));
        cmd_backlog.push_back(make_cmd(FUNC_FIND, peer_c, 8'd0, 6'd0, '0, 1'b0));
        cmd_backlog.push_back(make_cmd(FUNC_UNUSED, MAC_ZERO, 8'd0, 6'd0, '0, 1'b0));
        cmd_backlog.push_back(make_cmd(FUNC_REMOVE, MAC_ZERO, 8'd0, 6'd0, '0, 1'b0));
        cmd_backlog.push_back(make_cmd(FUNC_REMOVE, MAC_ZERO, 8'd0, 6'd0, '0, 1'b0));
    endtask

    // Random traffic. Addresses mostly come from a small pool, refreshed now and
    // then, so that refreshes, hits and a full table are common.
    task automatic load_random();
        logic [MAC_W-1:0] peer_pool[6];
        table_cmd_t       c;
        int unsigned      pick;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 120 == 0)
                foreach (peer_pool[k])
                    peer_pool[k] = random_mac();
            pick = $urandom_range(99);
            if (pick < 45)
                c.func = FUNC_ADD;
            else if (pick < 70)
                c.func = FUNC_REMOVE;
            else if (pick < 95)
                c.func = FUNC_FIND;
            else
                c.func = FUNC_UNUSED;
            pick = $urandom_range(99);
            if (pick < 5)
                c.mac = MAC_ZERO;
            else if (pick < 10)
                c.mac = MAC_ONES;
            else if (pick < 80)
                c.mac = peer_pool[$urandom_range(5)];
            else
                c.mac = random_mac();
            c.mode = ($urandom_range(99) < 40) ? 8'd0 : 8'($urandom_range(255, 1));
            c.index = ($urandom_range(9) < 8) ? 6'($urandom_range(4)) : 6'($urandom_range(63));
            c.now = $urandom;
            c.drain = (n % 250 == 0);
            cmd_backlog.push_back(c);
        end
    endtask

    // Command driver: holds a beat until accepted, with random gaps between beats.
    always @(negedge clk)
    begin
        table_cmd_t next_cmd;
        if (!rst_n)
            start <= 1'b0;
        else if (start && !took_beat)
        begin
            // Beat still waiting for the block to take it.
        end
        else if (cmd_backlog.size() == 0)
            start <= 1'b0;
        else if (cmd_backlog[0].drain && table_outcomes.size() != 0)
            start <= 1'b0;
        else if (!(sent_count >= QUIET_FROM && sent_count < QUIET_TO)
                 && $urandom_range(99) < 16)
            start <= 1'b0;
        else
        begin
            next_cmd = cmd_backlog.pop_front();
            func <= next_cmd.func;
            mac <= next_cmd.mac;
            pedal_mode <= next_cmd.mode;
            entry_index <= next_cmd.index;
            now_ms <= next_cmd.now;
            start <= 1'b1;
            sent_count++;
        end
    end

    // Result monitor and predictor: checks each result beat, then predicts the
    // result of any command beat taken at this edge.
    always @(posedge clk)
    begin
        table_outcome_t want;
        table_cmd_t     seen_cmd;
        if (!rst_n)
        begin
            foreach (peer_table[i])
                peer_table[i] = '0;
            peer_count = 0;
            slots_used = 0;
            took_beat = 1'b0;
        end
        else
        begin
            if (done)
            begin
                if (table_outcomes.size() == 0)
                    report_mismatch("result beat with nothing outstanding", 1, 0);
                else
                begin
                    want = table_outcomes.pop_front();
                    if (ok !== want.ok)
                        report_mismatch("ok", ok, want.ok);
                    if (found !== want.found)
                        report_mismatch("found", found, want.found);
                    if (found_index !== want.found_index)
                        report_mismatch("found_index", found_index, want.found_index);
                    if (available_slots !== want.avail)
                        report_mismatch("available_slots", available_slots, want.avail);
                    if (entry_count !== want.count)
                        report_mismatch("entry_count", entry_count, want.count);
                end
            end
            took_beat = start && !busy;
            if (took_beat)
            begin
                seen_cmd = '{func, mac, pedal_mode, entry_index, now_ms, 1'b0};
                want = apply_table_op(seen_cmd);
                table_outcomes.push_back(want);
                op_tally[func]++;
                if (want.ok)
                    ok_tally++;
            end
            // Watchdog on cycles where neither channel moves a beat.
            if (took_beat || done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog expired after %0d idle cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Reset, stimulus and end of run.
    initial
    begin
        load_directed();
        load_random();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        while (cmd_backlog.size() != 0 || start || table_outcomes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Run covered %0d adds, %0d removals, %0d finds, %0d unused selectors;",
                 op_tally[FUNC_ADD], op_tally[FUNC_REMOVE], op_tally[FUNC_FIND],
                 op_tally[FUNC_UNUSED]);
        $display("%0d beats succeeded or hit, %0d mismatches.", ok_tally, mismatch_count);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
